// ===== rtl/didu_pkg.sv =====
package didu_pkg;

	// Width of the running target position
	localparam int POS_BITS = 32;
	// Width of a copy length
	localparam int LEN_W = 24;
	// Width of one position step: a copy length, or the default copy length
	localparam int ADV_W = LEN_W + 1;
	// Width of the saturating position sum
	localparam int SUM_W = ((POS_BITS > ADV_W) ? POS_BITS : ADV_W) + 1;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// Varint shift steps and limits
	localparam logic [5:0] VARINT_STEP  = 6'd7;
	localparam logic [5:0] VARINT_TOP   = 6'd28;
	localparam logic [5:0] VARINT_LIMIT = 6'd35;

	// Copy length when the size field decodes to zero
	localparam logic [LEN_W-1:0] COPY_DEFAULT_LEN = LEN_W'(32'h0001_0000);

	typedef enum logic [5:0] {
		PH_SRC   = 6'b000001,
		PH_TGT   = 6'b000010,
		PH_OP    = 6'b000100,
		PH_COPY  = 6'b001000,
		PH_LIT   = 6'b010000,
		PH_DRAIN = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		K_SRC  = 3'd0,
		K_TGT  = 3'd1,
		K_COPY = 3'd2,
		K_LIT  = 3'd3,
		K_ERR  = 3'd4
	} kind_t;

	typedef struct packed {
		phase_t                phase;
		logic [31:0]           varint_accum;
		logic [5:0]            varint_shift;
		logic [6:0]            operand_mask;
		logic [31:0]           copy_offset;
		logic [LEN_W-1:0]      copy_size;
		logic [6:0]            literal_remaining;
		logic [POS_BITS-1:0]   target_pos;
	} state_t;

	typedef struct packed {
		kind_t                 kind;
		logic [31:0]           offset;
		logic [LEN_W-1:0]      length;
		logic [7:0]            literal;
		logic [31:0]           target_pos;
		logic                  last;
	} result_t;

	// State at reset and at the end of every delta
	function automatic state_t reset_state();
		state_t s;
		s = '0;
		s.phase = PH_SRC;
		return s;
	endfunction

	// Drop all per-item fields, keep phase and position
	function automatic state_t clear_item(state_t s_in);
		state_t s;
		s = s_in;
		s.varint_accum = '0;
		s.varint_shift = '0;
		s.operand_mask = '0;
		s.copy_offset = '0;
		s.copy_size = '0;
		s.literal_remaining = '0;
		return s;
	endfunction

	// Position as shown on the result, saturated to 32 bits
	function automatic logic [31:0] pos_out(logic [POS_BITS-1:0] p);
		logic [63:0] w;
		w = 64'(p);
		if (w > 64'h0000_0000_FFFF_FFFF) begin
			return '1;
		end
		return w[31:0];
	endfunction

	// Advance the position, holding at all ones
	function automatic logic [POS_BITS-1:0] advance(logic [POS_BITS-1:0] p,
			logic [ADV_W-1:0] n);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(p) + SUM_W'(n);
		if (sum > SUM_W'(POS_MAX)) begin
			return POS_MAX;
		end
		return sum[POS_BITS-1:0];
	endfunction

endpackage

// ===== rtl/didu_decode.sv =====
module didu_decode (
	input  didu_pkg::state_t  st,
	input  logic [7:0]        delta_byte,
	input  logic              byte_last,
	output didu_pkg::state_t  nxt,
	output logic              emit,
	output didu_pkg::result_t res
);
	import didu_pkg::*;

	logic [6:0]       payload;
	logic [31:0]      varint_next;
	logic [6:0]       low_bit;
	logic [6:0]       mask_rest;
	logic [31:0]      offset_next;
	logic [LEN_W-1:0] size_next;
	logic [6:0]       remaining_next;
	logic             fail;
	logic             copy_go;
	logic [31:0]      copy_off;
	logic [LEN_W-1:0] copy_len;
	logic             lit_go;

	assign payload = delta_byte[6:0];
	assign varint_next = st.varint_accum | (32'({25'b0, payload}) << st.varint_shift);

	// Take the lowest pending operand bit
	assign low_bit = st.operand_mask & ~(st.operand_mask - 7'd1);
	assign mask_rest = st.operand_mask & (st.operand_mask - 7'd1);

	// Merge the operand byte into its offset or size lane
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			offset_next[8*i +: 8] = st.copy_offset[8*i +: 8] | (low_bit[i] ? delta_byte : 8'h00);
		end
		for (int i = 0; i < 3; i++) begin
			size_next[8*i +: 8] = st.copy_size[8*i +: 8] | (low_bit[4+i] ? delta_byte : 8'h00);
		end
	end

	assign remaining_next = (st.literal_remaining == 7'd0) ? 7'd0 : st.literal_remaining - 7'd1;

	// Step the decoder by one byte
	always_comb begin
		nxt = st;
		emit = 1'b0;
		fail = 1'b0;
		copy_go = 1'b0;
		copy_off = '0;
		copy_len = '0;
		lit_go = 1'b0;
		res = '0;
		res.kind = K_ERR;
		res.target_pos = pos_out(st.target_pos);
		res.last = byte_last;

		unique case (st.phase)
			PH_SRC, PH_TGT: begin
				if (st.varint_shift >= VARINT_LIMIT ||
						(st.varint_shift == VARINT_TOP && payload[6:4] != 3'd0)) begin
					fail = 1'b1;
				end else if (delta_byte[7]) begin
					if (byte_last) begin
						fail = 1'b1;
					end else begin
						nxt.varint_accum = varint_next;
						nxt.varint_shift = st.varint_shift + VARINT_STEP;
					end
				end else if (st.phase == PH_SRC && byte_last) begin
					fail = 1'b1;
				end else begin
					emit = 1'b1;
					res.kind = (st.phase == PH_SRC) ? K_SRC : K_TGT;
					res.offset = varint_next;
					nxt.phase = (st.phase == PH_SRC) ? PH_TGT : PH_OP;
					nxt.varint_accum = '0;
					nxt.varint_shift = '0;
				end
			end
			PH_OP: begin
				if (delta_byte[7]) begin
					if (payload == 7'd0) begin
						copy_go = 1'b1;
					end else if (byte_last) begin
						fail = 1'b1;
					end else begin
						nxt = clear_item(st);
						nxt.operand_mask = payload;
						nxt.phase = PH_COPY;
					end
				end else if (delta_byte == 8'd0 || byte_last) begin
					fail = 1'b1;
				end else begin
					nxt.literal_remaining = payload;
					nxt.phase = PH_LIT;
				end
			end
			PH_COPY: begin
				if (st.operand_mask == 7'd0) begin
					copy_go = 1'b1;
					copy_off = st.copy_offset;
					copy_len = st.copy_size;
				end else if (mask_rest != 7'd0) begin
					if (byte_last) begin
						fail = 1'b1;
					end else begin
						nxt.copy_offset = offset_next;
						nxt.copy_size = size_next;
						nxt.operand_mask = mask_rest;
					end
				end else begin
					copy_go = 1'b1;
					copy_off = offset_next;
					copy_len = size_next;
				end
			end
			PH_LIT: begin
				if (byte_last && st.literal_remaining != 7'd1) begin
					fail = 1'b1;
				end else begin
					lit_go = 1'b1;
				end
			end
			default: begin
				// discard bytes until the end of the delta
			end
		endcase

		// Emit a copy command and advance by its length
		if (copy_go) begin
			emit = 1'b1;
			res.kind = K_COPY;
			res.offset = copy_off;
			res.length = (copy_len == '0) ? COPY_DEFAULT_LEN : copy_len;
			nxt = clear_item(st);
			nxt.target_pos = advance(st.target_pos, ADV_W'(res.length));
			nxt.phase = PH_OP;
		end

		// Emit a literal byte and advance by one
		if (lit_go) begin
			emit = 1'b1;
			res.kind = K_LIT;
			res.literal = delta_byte;
			nxt.target_pos = advance(st.target_pos, ADV_W'(1));
			nxt.literal_remaining = remaining_next;
			if (remaining_next == 7'd0) begin
				nxt.phase = PH_OP;
			end
		end

		// Give an error and drop the rest of the delta
		if (fail) begin
			emit = 1'b1;
			res.kind = K_ERR;
			res.offset = '0;
			res.length = '0;
			res.literal = '0;
			nxt = clear_item(st);
			nxt.phase = PH_DRAIN;
		end

		// The final byte always returns the decoder to reset
		if (byte_last) begin
			nxt = reset_state();
		end
	end

endmodule

// ===== rtl/delta_instruction_decoder_unit.sv =====
// Pipeline: an accepted byte is held in the input register and decoded from there,
// and its result word is then loaded into the result register.
// Throughput: one delta byte per cycle; input stalls only while the held byte
// gives a result word, the result register is full and result_ready is low.
// Reset (arst_n low) clears the decoder to the start of a delta, target position 0,
// and empties both registers.
module delta_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        delta_valid,
	output logic        delta_ready,
	input  logic [7:0]  delta_byte,
	input  logic        byte_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  out_kind,
	output logic [31:0] out_offset,
	output logic [23:0] out_length,
	output logic [7:0]  out_literal,
	output logic [31:0] out_target_pos,
	output logic        out_last
);
	import didu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_next;
	logic       emit;
	result_t    res;
	result_t    res_q;
	logic       res_valid_q;
	logic       consume;

	didu_decode u_decode (
		.st         (state_q),
		.delta_byte (byte_s1),
		.byte_last  (last_s1),
		.nxt        (state_next),
		.emit       (emit),
		.res        (res)
	);

	// Advance the held byte when its result word has room, or when it gives none
	assign consume = valid_s1 && (!emit || !res_valid_q || result_ready);
	assign delta_ready = !valid_s1 || consume;

	// Hold the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (delta_ready) begin
			valid_s1 <= delta_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (delta_ready && delta_valid) begin
			byte_s1 <= delta_byte;
			last_s1 <= byte_last;
		end
	end

	// Update decoder state once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= reset_state();
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	// Load the result word, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (consume && emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign out_kind = res_q.kind;
	assign out_offset = res_q.offset;
	assign out_length = res_q.length;
	assign out_literal = res_q.literal;
	assign out_target_pos = res_q.target_pos;
	assign out_last = res_q.last;

`ifndef SYNTH
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> state_q.phase == PH_SRC && state_q.target_pos == '0)
		else $error("final byte did not return decoder to reset");

	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && state_q.phase == PH_DRAIN |-> !emit)
		else $error("result produced while discarding");

	a_copy_mask: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_COPY |-> state_q.operand_mask != 7'd0)
		else $error("copy operand phase with empty mask");

	a_pos_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !last_s1 |=> state_q.target_pos >= $past(state_q.target_pos))
		else $error("target position moved backwards");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import didu_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int N_PLAN      = 27;

	// One delta byte, with a hand-written result word where one is given
	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		bit          typed;
		kind_t       kind;
		logic [31:0] off;
		logic [23:0] len;
		logic [7:0]  lit;
		logic [31:0] pos;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        delta_valid = 1'b0;
	logic        delta_ready;
	logic [7:0]  delta_byte = 8'h00;
	logic        byte_last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  out_kind;
	logic [31:0] out_offset;
	logic [23:0] out_length;
	logic [7:0]  out_literal;
	logic [31:0] out_target_pos;
	logic        out_last;

	// Directed deltas: header extremes, full copy, empty-mask copy, insert,
	// overlong varint, truncated header, reserved opcode
	row_t plan [N_PLAN] = '{
		'{8'h00, 1'b0, 1'b1, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h0F, 1'b0, 1'b1, K_TGT,  32'hFFFF_FFFF, 24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b0, 1'b1, K_COPY, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h01, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'hFF, 1'b1, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h80, 1'b0, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h10, 1'b0, 1'b1, K_ERR,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h55, 1'b1, 1'b0, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h05, 1'b1, 1'b1, K_ERR,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h00, 1'b0, 1'b1, K_SRC,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h00, 1'b0, 1'b1, K_TGT,  32'h0,         24'h0,      8'h0, 32'h0},
		'{8'h00, 1'b1, 1'b1, K_ERR,  32'h0,         24'h0,      8'h0, 32'h0}
	};

	row_t    stim_q[$];
	result_t pending_words[$];
	row_t    cur;
	int      n_items = 0;
	int      next_idx = 0;
	int      n_taken = 0;
	int      mismatches = 0;
	int      cycles = 0;
	bit      in_take = 1'b0;

	// Decoder state as predicted
	phase_t      dec_phase = PH_SRC;
	logic [31:0] vacc = '0;
	int          vshift = 0;
	logic [6:0]  opmask = '0;
	logic [31:0] copy_off = '0;
	logic [23:0] copy_len = '0;
	logic [6:0]  lit_left = '0;
	logic [31:0] tpos = '0;

	delta_instruction_decoder_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.delta_valid    (delta_valid),
		.delta_ready    (delta_ready),
		.delta_byte     (delta_byte),
		.byte_last      (byte_last),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.out_kind       (out_kind),
		.out_offset     (out_offset),
		.out_length     (out_length),
		.out_literal    (out_literal),
		.out_target_pos (out_target_pos),
		.out_last       (out_last)
	);

	always #5 clk = ~clk;

	// Drop per-item fields, keep phase and position
	function automatic void clear_fields();
		vacc = '0;
		vshift = 0;
		opmask = '0;
		copy_off = '0;
		copy_len = '0;
		lit_left = '0;
	endfunction

	function automatic void restart_delta();
		clear_fields();
		dec_phase = PH_SRC;
		tpos = '0;
	endfunction

	// Advance the target position, holding at all ones
	function automatic void move_pos(logic [24:0] n);
		logic [32:0] sum;
		sum = {1'b0, tpos} + 33'(n);
		tpos = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic result_t make_word(kind_t k, logic [31:0] off, logic [23:0] len,
			logic [7:0] lit, logic last);
		result_t w;
		w.kind = k;
		w.offset = off;
		w.length = len;
		w.literal = lit;
		w.target_pos = tpos;
		w.last = last;
		return w;
	endfunction

	// Issue the pending copy command and return to opcode decoding
	function automatic result_t issue_copy(logic last);
		result_t w;
		logic [24:0] n;
		n = (copy_len != '0) ? {1'b0, copy_len} : 25'h1_0000;
		w = make_word(K_COPY, copy_off, n[23:0], 8'h00, last);
		move_pos(n);
		clear_fields();
		dec_phase = PH_OP;
		return w;
	endfunction

	// Step the predicted decoder by one delta byte; 1 when a word results
	function automatic bit decode_byte(logic [7:0] b, logic last, output result_t w);
		bit bad;
		bit got;
		int bitn;
		bad = 1'b0;
		got = 1'b0;
		w = '0;
		case (dec_phase) inside
		PH_SRC, PH_TGT: begin
			if (vshift >= 35 || (vshift == 28 && b[6:4] != 3'd0)) begin
				bad = 1'b1;
			end else begin
				vacc = vacc | (32'(b[6:0]) << vshift);
				if (b[7]) begin
					if (last) bad = 1'b1;
					else vshift += 7;
				end else if (dec_phase == PH_SRC && last) begin
					bad = 1'b1;
				end else begin
					w = make_word((dec_phase == PH_SRC) ? K_SRC : K_TGT, vacc, '0, '0, last);
					got = 1'b1;
					dec_phase = (dec_phase == PH_SRC) ? PH_TGT : PH_OP;
					vacc = '0;
					vshift = 0;
				end
			end
		end
		PH_OP: begin
			if (b[7]) begin
				clear_fields();
				opmask = b[6:0];
				if (opmask == '0) begin
					w = issue_copy(last);
					got = 1'b1;
				end else if (last) begin
					bad = 1'b1;
				end else begin
					dec_phase = PH_COPY;
				end
			end else if (b == 8'h00 || last) begin
				bad = 1'b1;
			end else begin
				lit_left = b[6:0];
				dec_phase = PH_LIT;
			end
		end
		PH_COPY: begin
			// take the operand for the lowest mask bit still set
			bitn = 0;
			while (bitn < 6 && !opmask[bitn]) bitn++;
			if (bitn < 4) copy_off = copy_off | (32'(b) << (8 * bitn));
			else copy_len = copy_len | (24'(b) << (8 * (bitn - 4)));
			opmask[bitn] = 1'b0;
			if (opmask != '0) begin
				if (last) bad = 1'b1;
			end else begin
				w = issue_copy(last);
				got = 1'b1;
			end
		end
		PH_LIT: begin
			if (last && lit_left != 7'd1) begin
				bad = 1'b1;
			end else begin
				w = make_word(K_LIT, '0, '0, b, last);
				got = 1'b1;
				move_pos(25'd1);
				if (lit_left != '0) lit_left--;
				if (lit_left == '0) dec_phase = PH_OP;
			end
		end
		default: begin
		end
		endcase
		// error word, then discard until the end of the delta
		if (bad) begin
			w = make_word(K_ERR, '0, '0, '0, last);
			got = 1'b1;
			if (!last) begin
				clear_fields();
				dec_phase = PH_DRAIN;
			end
		end
		if (last) restart_delta();
		return got;
	endfunction

	function automatic logic [7:0] rand_octet();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 3))
		0: return 32'($urandom_range(0, 127));
		1: return 32'($urandom_range(128, 65535));
		2: return $urandom;
		default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic push_octet(logic [7:0] b);
		row_t r;
		r = '0;
		r.b = b;
		stim_q.push_back(r);
	endtask

	task automatic push_varint(logic [31:0] v);
		while (v > 32'h7F) begin
			push_octet({1'b1, v[6:0]});
			v = v >> 7;
		end
		push_octet({1'b0, v[6:0]});
	endtask

	task automatic mark_last();
		row_t r;
		r = stim_q[stim_q.size() - 1];
		r.last = 1'b1;
		stim_q[stim_q.size() - 1] = r;
	endtask

	// One random delta: mostly well formed, some noise, cut short or corrupted
	task automatic add_delta();
		int start;
		int flavour;
		int len;
		int cut;
		int k;
		logic [6:0] mask;
		row_t r;
		start = stim_q.size();
		flavour = $urandom_range(0, 99);
		if (flavour < 6) begin
			repeat ($urandom_range(1, 12)) push_octet(rand_octet());
		end else if (flavour < 12) begin
			// overlong header varint followed by junk
			repeat (4) push_octet(8'h80 | rand_octet());
			repeat ($urandom_range(1, 4)) push_octet(rand_octet());
		end else begin
			push_varint(rand_size());
			push_varint(rand_size());
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 1)) begin
					mask = ($urandom_range(0, 7) == 0) ? 7'h00 : 7'($urandom);
					push_octet({1'b1, mask});
					for (int i = 0; i < 7; i++)
						if (mask[i]) push_octet(rand_octet());
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
						: $urandom_range(1, 6);
					push_octet(8'(len));
					repeat (len) push_octet(rand_octet());
				end
			end
			if (flavour < 24) begin
				// end the delta early
				cut = $urandom_range(start, stim_q.size() - 1);
				while (stim_q.size() > cut + 1) void'(stim_q.pop_back());
			end else if (flavour < 32) begin
				// overwrite one byte
				k = $urandom_range(start, stim_q.size() - 1);
				r = stim_q[k];
				r.b = rand_octet();
				stim_q[k] = r;
			end
		end
		mark_last();
	endtask

	// Enough maximum-length copies to drive the target position into saturation
	task automatic add_long_delta();
		push_varint(32'h0);
		push_varint(32'hFFFF_FFFF);
		repeat (258) begin
			push_octet(8'hF0);
			repeat (3) push_octet(8'hFF);
		end
		push_octet(8'h01);
		push_octet(rand_octet());
		push_octet(8'h80);
		mark_last();
	endtask

	// Idling phases: none, sender idle, receiver stalling, both
	function automatic int idle_phase();
		int m;
		m = next_idx * 4 / (n_items + 1);
		return (m > 3) ? 3 : m;
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Sample handshakes and check result words between edges
	always @(negedge clk) begin
		result_t e;
		in_take = arst_n && delta_valid && delta_ready;
		if (arst_n && result_valid && result_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: out_kind %0d", out_kind);
				mismatches++;
			end else begin
				e = pending_words.pop_front();
				cmp_field("out_kind", 32'(e.kind), 32'(out_kind));
				cmp_field("out_offset", e.offset, out_offset);
				cmp_field("out_length", 32'(e.length), 32'(out_length));
				cmp_field("out_literal", 32'(e.literal), 32'(out_literal));
				cmp_field("out_target_pos", e.target_pos, out_target_pos);
				cmp_field("out_last", 32'(e.last), 32'(out_last));
			end
		end
	end

	// Predict each accepted byte, then present the next one or idle
	always @(posedge clk) begin
		result_t w;
		bit got;
		int pct;
		if (arst_n) begin
			if (in_take) begin
				got = decode_byte(cur.b, cur.last, w);
				if (cur.typed) begin
					w.kind = cur.kind;
					w.offset = cur.off;
					w.length = cur.len;
					w.literal = cur.lit;
					w.target_pos = cur.pos;
					w.last = cur.last;
					pending_words.push_back(w);
				end else if (got) begin
					pending_words.push_back(w);
				end
				n_taken++;
			end
			if (!delta_valid || in_take) begin
				pct = (idle_phase() == 1) ? 76 : (idle_phase() == 3) ? 26 : 0;
				if (next_idx < n_items && $urandom_range(0, 99) >= pct) begin
					cur = stim_q[next_idx];
					next_idx++;
					delta_valid <= 1'b1;
					delta_byte <= cur.b;
					byte_last <= cur.last;
				end else begin
					delta_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side
	always @(posedge clk) begin
		int pct;
		pct = (idle_phase() == 2) ? 76 : (idle_phase() == 3) ? 26 : 0;
		result_ready <= arst_n && ($urandom_range(0, 99) >= pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("delta_instruction_decoder_unit test failed");
			$finish;
		end
	end

	initial begin
		int mark;
		foreach (plan[i]) stim_q.push_back(plan[i]);
		while (stim_q.size() < N_PLAN + 190) add_delta();
		add_long_delta();
		mark = stim_q.size();
		while (stim_q.size() < mark + 190) add_delta();
		n_items = stim_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all bytes taken, all words back, then a short tail
		while (n_taken < n_items) @(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("delta_instruction_decoder_unit test passed");
		end else begin
			$display("delta_instruction_decoder_unit test failed");
		end
		$finish;
	end

endmodule
